FILE: rtl/core/lsrc_pkg.sv
// shared types, widths and constants of the segment clipper
package lsrc_pkg;

  localparam int COORD_BITS   = 12;
  localparam int DIFF_BITS    = COORD_BITS + 1;
  localparam int DIV_BITS     = COORD_BITS + 2;
  localparam int T_FRAC       = 16;
  localparam int T_BITS       = T_FRAC + 1;
  localparam int PROD_BITS    = T_BITS + 1 + DIFF_BITS;
  localparam int NUM_EDGES    = 4;
  localparam int CFG_IDX_BITS = 2;
  // lane load, one stage per quotient bit, rounding correction
  localparam int DIV_LAT      = T_BITS + 2;

  localparam logic [T_BITS-1:0] T_ONE = T_BITS'(1) << T_FRAC;

  localparam logic [CFG_IDX_BITS-1:0] REG_X_MIN = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_Y_MIN = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_X_MAX = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_Y_MAX = 2'd3;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;

  localparam coord_t WIN_MIN_RST = -COORD_BITS'(120);
  localparam coord_t WIN_MAX_RST = COORD_BITS'(120);

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } in_t;

  typedef struct packed {
    coord_t clipped_start_x;
    coord_t clipped_start_y;
    coord_t clipped_end_x;
    coord_t clipped_end_y;
    logic   visible;
  } out_t;

  typedef struct packed {
    coord_t                 x0;
    coord_t                 y0;
    diff_t                  dx;
    diff_t                  dy;
    logic                   vis;
    logic [NUM_EDGES-1:0]   use_edge;
    logic [NUM_EDGES-1:0]   ent;
  } seg_meta_t;

endpackage

FILE: rtl/core/lsrc_div.sv
// pipelined restoring divider lane: t = round(num / den) in q1.16, num <= den
module lsrc_div
  import lsrc_pkg::*;
(
  input  logic                clk,
  input  logic                en,
  input  logic [DIV_BITS-1:0] num_i,
  input  logic [DIV_BITS-1:0] den_i,
  output logic [T_BITS-1:0]   t_o
);

  logic [DIV_BITS-1:0] rem_r [0:T_BITS];
  logic [DIV_BITS-1:0] dvs_r [0:T_BITS];
  logic [DIV_BITS-1:0] den_r [0:T_BITS];
  logic [T_BITS-1:0]   quo_r [0:T_BITS];
  logic [T_BITS-1:0]   t_r;
  logic [DIV_BITS:0]   corr_sum;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num_i;
      dvs_r[0] <= {den_i[DIV_BITS-2:0], 1'b0};
      den_r[0] <= den_i;
      quo_r[0] <= '0;
    end
  end

  for (genvar k = 0; k < T_BITS; k++) begin : g_step
    logic [DIV_BITS-1:0] shifted;
    logic                ge;
    assign shifted = {rem_r[k][DIV_BITS-2:0], 1'b0};
    assign ge      = shifted >= dvs_r[k];
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= ge ? shifted - dvs_r[k] : shifted;
        dvs_r[k+1] <= dvs_r[k];
        den_r[k+1] <= den_r[k];
        quo_r[k+1] <= {quo_r[k][T_BITS-2:0], ge};
      end
    end
  end

  // adding den to the remainder gives round-half-up of the quotient
  assign corr_sum = {1'b0, rem_r[T_BITS]} + {1'b0, den_r[T_BITS]};

  always_ff @(posedge clk) begin
    if (en) begin
      t_r <= quo_r[T_BITS] + T_BITS'(corr_sum >= {1'b0, dvs_r[T_BITS]});
    end
  end

  assign t_o = t_r;

endmodule

FILE: rtl/core/line_segment_rect_clipper.sv
// Cyrus-Beck segment clipper against a register-held rectangular window
//
// Input beats carry a segment (start and end point), output beats carry the
// clipped end points and a visible flag; a hidden segment gives zero points.
// The window is four registers written over the cfg channel (index 0..3:
// x min, y min, x max, y max); cfg_ready is always high and writes are to
// be made only while no segment is in flight.
// The path from input beat to output beat is one input register,
// a 19-stage divider (load, one quotient bit per stage for 17 bits of t,
// rounding), t selection, multiply, and round/offset into the output
// register. While no output beat is held, one segment is taken every cycle.
// The whole pipeline moves as one: when the output beat is held by
// out_stall, every stage freezes and in_stall is raised in the same cycle.
// Reset clears all valid bits and loads the window with -120..120 on both
// axes.
module line_segment_rect_clipper
  import lsrc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  in_t                     in_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output out_t                    out_data,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  coord_t                  cfg_data
);

  logic adv;

  coord_t win_x_min_r, win_y_min_r, win_x_max_r, win_y_max_r;

  logic      in_vld_r;
  in_t       in_r;
  logic      vld_r  [0:DIV_LAT-1];
  seg_meta_t meta_r [0:DIV_LAT-1];

  // edge decode
  diff_t               dx, dy;
  coord_t              edge_pos [NUM_EDGES];
  coord_t              edge_org [NUM_EDGES];
  diff_t               edge_dlt [NUM_EDGES];
  diff_t               num_raw  [NUM_EDGES];
  diff_t               num_e    [NUM_EDGES];
  diff_t               den_e    [NUM_EDGES];
  logic [NUM_EDGES-1:0] ent_e, use_e, kill_e;
  logic                x_out, y_out;
  seg_meta_t           meta_nxt;
  logic [T_BITS-1:0]   t_lane [NUM_EDGES];

  // selection
  logic [T_BITS-1:0] te_nxt, tl_nxt;
  logic              sel_vld_r, sel_vis_r;
  logic [T_BITS-1:0] te_r, tl_r;
  coord_t            sel_x0_r, sel_y0_r;
  diff_t             sel_dx_r, sel_dy_r;

  // multiply
  logic                        mul_vld_r, mul_vis_r;
  coord_t                      mul_x0_r, mul_y0_r;
  logic signed [PROD_BITS-1:0] p_sx_r, p_sy_r, p_ex_r, p_ey_r;

  logic out_valid_r;
  out_t out_r, out_nxt;

  assign adv       = !(out_valid_r && out_stall);
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_x_min_r <= WIN_MIN_RST;
      win_y_min_r <= WIN_MIN_RST;
      win_x_max_r <= WIN_MAX_RST;
      win_y_max_r <= WIN_MAX_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_X_MIN: win_x_min_r <= cfg_data;
        REG_Y_MIN: win_y_min_r <= cfg_data;
        REG_X_MAX: win_x_max_r <= cfg_data;
        REG_Y_MAX: win_y_max_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (adv) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in_r <= in_data;
    end
  end

  assign dx = diff_t'(in_r.end_x) - diff_t'(in_r.start_x);
  assign dy = diff_t'(in_r.end_y) - diff_t'(in_r.start_y);

  always_comb begin
    edge_pos[0] = win_x_min_r; edge_org[0] = in_r.start_x; edge_dlt[0] = dx;
    edge_pos[1] = win_y_min_r; edge_org[1] = in_r.start_y; edge_dlt[1] = dy;
    edge_pos[2] = win_x_max_r; edge_org[2] = in_r.start_x; edge_dlt[2] = dx;
    edge_pos[3] = win_y_max_r; edge_org[3] = in_r.start_y; edge_dlt[3] = dy;
    for (int e = 0; e < NUM_EDGES; e++) begin
      num_raw[e] = diff_t'(edge_pos[e]) - diff_t'(edge_org[e]);
      // min edges enter on positive delta, max edges on negative
      ent_e[e]   = (e < 2) ? (edge_dlt[e] > 0) : (edge_dlt[e] < 0);
      num_e[e]   = (edge_dlt[e] < 0) ? -num_raw[e] : num_raw[e];
      den_e[e]   = (edge_dlt[e] < 0) ? -edge_dlt[e] : edge_dlt[e];
      use_e[e]   = (edge_dlt[e] != 0) && (num_e[e] >= 0) && (num_e[e] <= den_e[e]);
      kill_e[e]  = (edge_dlt[e] != 0) &&
                   (((num_e[e] < 0) && !ent_e[e]) || ((num_e[e] > den_e[e]) && ent_e[e]));
    end
    x_out = (dx == 0) && ((in_r.start_x < win_x_min_r) || (in_r.start_x > win_x_max_r));
    y_out = (dy == 0) && ((in_r.start_y < win_y_min_r) || (in_r.start_y > win_y_max_r));
    meta_nxt.x0       = in_r.start_x;
    meta_nxt.y0       = in_r.start_y;
    meta_nxt.dx       = dx;
    meta_nxt.dy       = dy;
    meta_nxt.vis      = !(|kill_e) && !x_out && !y_out;
    meta_nxt.use_edge = use_e;
    meta_nxt.ent      = ent_e;
  end

  for (genvar e = 0; e < NUM_EDGES; e++) begin : g_lane
    lsrc_div u_div (
      .clk   (clk),
      .en    (adv),
      .num_i (DIV_BITS'($unsigned(num_e[e]))),
      .den_i (DIV_BITS'($unsigned(den_e[e]))),
      .t_o   (t_lane[e])
    );
  end

  // side data travels alongside the divider lanes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_LAT; k++) vld_r[k] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_vld_r;
      for (int k = 1; k < DIV_LAT; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      meta_r[0] <= meta_nxt;
      for (int k = 1; k < DIV_LAT; k++) meta_r[k] <= meta_r[k-1];
    end
  end

  always_comb begin
    te_nxt = '0;
    tl_nxt = T_ONE;
    for (int e = 0; e < NUM_EDGES; e++) begin
      if (meta_r[DIV_LAT-1].use_edge[e]) begin
        if (meta_r[DIV_LAT-1].ent[e]) begin
          if (t_lane[e] > te_nxt) te_nxt = t_lane[e];
        end else begin
          if (t_lane[e] < tl_nxt) tl_nxt = t_lane[e];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_vld_r <= 1'b0;
      mul_vld_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      sel_vld_r   <= vld_r[DIV_LAT-1];
      mul_vld_r   <= sel_vld_r;
      out_valid_r <= mul_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      te_r      <= te_nxt;
      tl_r      <= tl_nxt;
      sel_vis_r <= meta_r[DIV_LAT-1].vis && (te_nxt <= tl_nxt);
      sel_x0_r  <= meta_r[DIV_LAT-1].x0;
      sel_y0_r  <= meta_r[DIV_LAT-1].y0;
      sel_dx_r  <= meta_r[DIV_LAT-1].dx;
      sel_dy_r  <= meta_r[DIV_LAT-1].dy;

      mul_vis_r <= sel_vis_r;
      mul_x0_r  <= sel_x0_r;
      mul_y0_r  <= sel_y0_r;
      p_sx_r    <= $signed({1'b0, te_r}) * sel_dx_r;
      p_sy_r    <= $signed({1'b0, te_r}) * sel_dy_r;
      p_ex_r    <= $signed({1'b0, tl_r}) * sel_dx_r;
      p_ey_r    <= $signed({1'b0, tl_r}) * sel_dy_r;

      out_r     <= out_nxt;
    end
  end

  // round to nearest, ties away from zero, then offset from the start point
  function automatic coord_t place(input coord_t org, input logic signed [PROD_BITS-1:0] p);
    logic signed [PROD_BITS-1:0] half;
    logic signed [PROD_BITS-1:0] mag;
    logic signed [PROD_BITS-1:0] q;
    diff_t                       sum;
    half = PROD_BITS'(1) <<< (T_FRAC - 1);
    mag  = p[PROD_BITS-1] ? -p : p;
    q    = (mag + half) >>> T_FRAC;
    if (p[PROD_BITS-1]) q = -q;
    sum  = diff_t'(org) + q[DIFF_BITS-1:0];
    return sum[COORD_BITS-1:0];
  endfunction

  always_comb begin
    out_nxt = '0;
    if (mul_vis_r) begin
      out_nxt.clipped_start_x = place(mul_x0_r, p_sx_r);
      out_nxt.clipped_start_y = place(mul_y0_r, p_sy_r);
      out_nxt.clipped_end_x   = place(mul_x0_r, p_ex_r);
      out_nxt.clipped_end_y   = place(mul_y0_r, p_ey_r);
      out_nxt.visible         = 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: rtl/core/lsrc_checker.sv
// port-level checks for the segment clipper, bound to the top level
module lsrc_checker
  import lsrc_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data,
  input logic cfg_ready
);

  a_idle_after_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output beat right after reset");

  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> in_stall)
    else $error("input taken while output held");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("held output beat changed");

  a_hidden_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.visible) |->
      (out_data.clipped_start_x == 0 && out_data.clipped_start_y == 0 &&
       out_data.clipped_end_x == 0 && out_data.clipped_end_y == 0))
    else $error("hidden segment with nonzero points");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("cfg channel not ready");

endmodule

bind line_segment_rect_clipper lsrc_checker u_lsrc_checker (.*);

FILE: sim/tb.sv
// clipper testbench: directed and random segments checked against a built-in predictor
module tb;
  import lsrc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint T_UNIT = 65536;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  coord_t cfg_data;

  line_segment_rect_clipper dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  in_t seg_pending[$];
  out_t clip_expected[$];
  coord_t win_x_min, win_y_min, win_x_max, win_y_max;
  int mismatches;
  int burst_left;
  int gap_left;
  int stall_phase;
  bit hold_sender;
  bit cfg_req;
  logic [CFG_IDX_BITS-1:0] cfg_req_index;
  coord_t cfg_req_data;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // one window edge; updates entering/leaving t and visibility
  function automatic void clip_edge(input longint num, input longint den, input bit entering,
                                    inout longint t_in, inout longint t_out, inout bit vis);
    longint tq;
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    if (num < 0) begin
      if (!entering) vis = 1'b0;
    end else if (num > den) begin
      if (entering) vis = 1'b0;
    end else begin
      tq = (num * 2 * T_UNIT + den) / (2 * den);
      if (entering) begin
        if (tq > t_in) t_in = tq;
      end else begin
        if (tq < t_out) t_out = tq;
      end
    end
  endfunction

  function automatic longint lerp_round(input longint p0, input longint t, input longint d);
    longint prod;
    prod = t * d;
    if (prod >= 0) return p0 + (prod + T_UNIT / 2) / T_UNIT;
    return p0 - ((-prod + T_UNIT / 2) / T_UNIT);
  endfunction

  function automatic out_t clip_segment(input in_t s);
    out_t r;
    longint x0, y0, dx, dy, t_in, t_out;
    bit vis;
    x0 = s.start_x;
    y0 = s.start_y;
    dx = longint'(s.end_x) - x0;
    dy = longint'(s.end_y) - y0;
    t_in = 0;
    t_out = T_UNIT;
    vis = 1'b1;
    if (dx == 0) begin
      if (x0 < win_x_min || x0 > win_x_max) vis = 1'b0;
    end else begin
      clip_edge(longint'(win_x_min) - x0, dx, dx > 0, t_in, t_out, vis);
      clip_edge(longint'(win_x_max) - x0, dx, dx < 0, t_in, t_out, vis);
    end
    if (dy == 0) begin
      if (y0 < win_y_min || y0 > win_y_max) vis = 1'b0;
    end else begin
      clip_edge(longint'(win_y_min) - y0, dy, dy > 0, t_in, t_out, vis);
      clip_edge(longint'(win_y_max) - y0, dy, dy < 0, t_in, t_out, vis);
    end
    if (t_in > t_out) vis = 1'b0;
    r = '0;
    if (vis) begin
      r.clipped_start_x = coord_t'(lerp_round(x0, t_in, dx));
      r.clipped_start_y = coord_t'(lerp_round(y0, t_in, dy));
      r.clipped_end_x = coord_t'(lerp_round(x0, t_out, dx));
      r.clipped_end_y = coord_t'(lerp_round(y0, t_out, dy));
      r.visible = 1'b1;
    end
    return r;
  endfunction

  // driver: bursts and gaps, predicts at each accepted beat
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) clip_expected.push_back(clip_segment(in_data));
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (seg_pending.size() > 0 && !hold_sender) begin
          in_data <= seg_pending.pop_front();
          in_valid <= 1'b1;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern and result check
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_phase <= 0;
    end else begin
      stall_phase <= stall_phase + 1;
      if (stall_phase % 600 < 200) out_stall <= 1'b0;
      else if (stall_phase % 600 < 400) out_stall <= (stall_phase % 7) < 3;
      else out_stall <= $urandom_range(0, 2) == 0;
      if (out_valid && !out_stall) begin
        if (clip_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat %p", out_data);
        end else begin
          out_t e;
          e = clip_expected.pop_front();
          if (e !== out_data) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p got %p", e, out_data);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_valid <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      cfg_valid <= 1'b0;
    end else if (cfg_req && !cfg_valid) begin
      cfg_valid <= 1'b1;
      cfg_index <= cfg_req_index;
      cfg_data <= cfg_req_data;
    end
  end

  // request stays up until the write beat is seen
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input coord_t val);
    @(posedge clk);
    cfg_req_index = idx;
    cfg_req_data = val;
    cfg_req = 1'b1;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_req = 1'b0;
    case (idx)
      REG_X_MIN: win_x_min = val;
      REG_Y_MIN: win_y_min = val;
      REG_X_MAX: win_x_max = val;
      default: win_y_max = val;
    endcase
    @(posedge clk);
  endtask

  task automatic set_window(input coord_t x0, input coord_t y0, input coord_t x1,
                            input coord_t y1);
    write_reg(REG_X_MIN, x0);
    write_reg(REG_Y_MIN, y0);
    write_reg(REG_X_MAX, x1);
    write_reg(REG_Y_MAX, y1);
  endtask

  task automatic drain();
    while (seg_pending.size() > 0 || in_valid || clip_expected.size() > 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  function automatic in_t make_seg(input int a, input int b, input int c, input int d);
    in_t s;
    s.start_x = coord_t'(a);
    s.start_y = coord_t'(b);
    s.end_x = coord_t'(c);
    s.end_y = coord_t'(d);
    return s;
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 5))
      0: return coord_t'($urandom);
      1: return ($urandom_range(0, 1) == 1) ? coord_t'(2047) : coord_t'(-2048);
      default: return coord_t'($signed($urandom_range(0, 400)) - 200);
    endcase
  endfunction

  task automatic add_random(input int n);
    in_t s;
    repeat (n) begin
      s.start_x = rand_coord();
      s.start_y = rand_coord();
      s.end_x = ($urandom_range(0, 7) == 0) ? s.start_x : rand_coord();
      s.end_y = ($urandom_range(0, 7) == 0) ? s.start_y : rand_coord();
      seg_pending.push_back(s);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cfg_req = 1'b0;
    cfg_req_index = '0;
    cfg_req_data = '0;
    hold_sender = 1'b0;
    mismatches = 0;
    win_x_min = WIN_MIN_RST;
    win_y_min = WIN_MIN_RST;
    win_x_max = WIN_MAX_RST;
    win_y_max = WIN_MAX_RST;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: crossing, inside, outside, parallel, point, extremes
    seg_pending.push_back(make_seg(-2048, -2048, 2047, 2047));
    seg_pending.push_back(make_seg(2047, 2047, -2048, -2048));
    seg_pending.push_back(make_seg(-10, 5, 20, -7));
    seg_pending.push_back(make_seg(-300, 0, 300, 0));
    seg_pending.push_back(make_seg(0, -300, 0, 300));
    seg_pending.push_back(make_seg(-300, 200, 300, 200));
    seg_pending.push_back(make_seg(200, -300, 200, 300));
    seg_pending.push_back(make_seg(5, 5, 5, 5));
    seg_pending.push_back(make_seg(500, 500, 500, 500));
    seg_pending.push_back(make_seg(-500, 0, -200, 0));
    seg_pending.push_back(make_seg(200, 0, 500, 10));
    seg_pending.push_back(make_seg(-300, 250, 250, -300));
    seg_pending.push_back(make_seg(-120, -120, 120, 120));
    seg_pending.push_back(make_seg(-2048, 2047, 2047, -2048));
    seg_pending.push_back(make_seg(0, 0, 1, 2047));
    seg_pending.push_back(make_seg(119, 119, 121, 121));
    drain();

    add_random(150);
    // pause until the pipeline is empty mid-run
    while (seg_pending.size() > 75) @(posedge clk);
    hold_sender = 1'b1;
    while (in_valid || clip_expected.size() > 0) @(posedge clk);
    hold_sender = 1'b0;
    drain();

    set_window(-2048, -2048, 2047, 2047);
    seg_pending.push_back(make_seg(-2048, 0, 2047, 0));
    add_random(100);
    drain();

    set_window(10, -40, 60, 90);
    add_random(100);
    drain();

    // inverted window
    set_window(100, 100, -100, -100);
    add_random(40);
    drain();

    set_window(2047, -2048, 2047, -2048);
    seg_pending.push_back(make_seg(2047, -2048, 2047, -2048));
    add_random(30);
    drain();

    set_window(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
    add_random(80);
    drain();

    if (mismatches == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #2ms;
    $display("Some tests failed");
    $finish;
  end
endmodule

FILE: filelist.f
rtl/core/lsrc_pkg.sv
rtl/core/lsrc_div.sv
rtl/core/line_segment_rect_clipper.sv
rtl/core/lsrc_checker.sv
sim/tb.sv
